// File: hw/rtl/obot_pkg.sv
// Package: widths, controller states and command/status types for the box overlap test.
`default_nettype none
package obot_pkg;
   localparam int CoordWidth = 16;
   localparam int NormalFracBits = 14;
   localparam int VertsPerBox = 8;
   localparam int ProdWidth = 2 * CoordWidth;
   localparam int CrossWidth = ProdWidth + 1;
   localparam int DotWidth = ProdWidth + 2;
   localparam int NumAxes = 15;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_NORMAL = 1'b1;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_CROSS,
      ST_SCAN,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load_axis;
      logic       load_cross;
      logic       start_scan;
      logic       scan_step;
      logic       finish_axis;
      logic [3:0] axis_idx;
      logic [3:0] vert_idx;
   } cmd_type;

   typedef struct packed {
      logic axis_zero;
      logic separated;
      logic draining;
   } status_type;
endpackage
`default_nettype wire

// File: hw/rtl/obot_ctrl.sv
// Controller: walks the 15 candidate axes and the 16 vertices of each.
`default_nettype none
module obot_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire                     rsp_taken,
   input  obot_pkg::status_type    status,
   output obot_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    result_valid,
   output logic                    result_bit
);
   obot_pkg::state_type state_ff, state_in;
   logic [3:0] axis_ff, axis_in;
   logic [3:0] vert_ff, vert_in;
   logic       res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= obot_pkg::ST_IDLE;
         axis_ff <= '0;
         vert_ff <= '0;
         res_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         vert_ff <= vert_in;
         res_ff <= res_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      vert_in = vert_ff;
      res_in = res_ff;
      cmd = '0;
      cmd.axis_idx = axis_ff;
      cmd.vert_idx = vert_ff;
      case (state_ff)
         obot_pkg::ST_IDLE: begin
            if (start) begin
               axis_in = '0;
               res_in = 1'b1;
               state_in = obot_pkg::ST_AXIS;
            end
         end
         obot_pkg::ST_AXIS: begin
            // face normals load directly; cross axes need a product stage
            if (axis_ff < 4'd6) begin
               cmd.load_axis = 1'b1;
               state_in = obot_pkg::ST_SCAN;
            end else begin
               cmd.load_cross = 1'b1;
               state_in = obot_pkg::ST_CROSS;
            end
            vert_in = '0;
         end
         obot_pkg::ST_CROSS: begin
            cmd.load_axis = 1'b1;
            state_in = obot_pkg::ST_SCAN;
         end
         obot_pkg::ST_SCAN: begin
            if (vert_ff == 4'd0) cmd.start_scan = 1'b1;
            if (status.axis_zero) begin
               state_in = obot_pkg::ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               vert_in = vert_ff + 4'd1;
               if (vert_ff == 4'd15) state_in = obot_pkg::ST_DONE;
            end
         end
         obot_pkg::ST_DONE: begin
            // hold until the last vertex projection has landed
            if (!status.draining) begin
               cmd.finish_axis = 1'b1;
               if (status.separated) begin
                  res_in = 1'b0;
                  state_in = obot_pkg::ST_OUT;
               end else if (axis_ff == 4'(obot_pkg::NumAxes - 1)) begin
                  state_in = obot_pkg::ST_OUT;
               end else begin
                  axis_in = axis_ff + 4'd1;
                  state_in = obot_pkg::ST_AXIS;
               end
            end
         end
         obot_pkg::ST_OUT: begin
            if (rsp_taken) state_in = obot_pkg::ST_IDLE;
         end
         default: state_in = obot_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != obot_pkg::ST_IDLE);
   assign result_valid = (state_ff == obot_pkg::ST_OUT);
   assign result_bit = res_ff;

`ifndef ASSERT_OFF
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff < 4'(obot_pkg::NumAxes)) else $error("axis index out of range");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      result_valid && !rsp_taken |=> result_valid && $stable(result_bit))
      else $error("result dropped");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == obot_pkg::ST_IDLE) && start && !$past(reset)
      |=> state_ff == obot_pkg::ST_AXIS) else $error("start lost");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/obot_datapath.sv
// Datapath: vertex and normal stores, axis build, projection and interval compare.
`default_nettype none
module obot_datapath (
   input  wire                      clock,
   input  wire                      store_en,
   input  wire                      store_kind,
   input  wire                      store_box,
   input  wire [2:0]                store_slot,
   input  wire obot_pkg::coord_type store_x,
   input  wire obot_pkg::coord_type store_y,
   input  wire obot_pkg::coord_type store_z,
   input  obot_pkg::cmd_type        cmd,
   output obot_pkg::status_type     status
);
   localparam int CW = obot_pkg::CoordWidth;
   localparam int PW = obot_pkg::ProdWidth;
   localparam int XW = obot_pkg::CrossWidth;
   localparam int DW = obot_pkg::DotWidth;

   logic [3*CW-1:0] vert_mem [16];
   logic [3*CW-1:0] norm_ff [6];

   always_ff @(posedge clock) begin
      if (store_en) begin
         if (store_kind == obot_pkg::KIND_VERTEX)
            vert_mem[{store_box, store_slot}] <= {store_z, store_y, store_x};
         else if (store_slot < 3'd3)
            norm_ff[3'(store_box) * 3'd3 + store_slot] <= {store_z, store_y, store_x};
      end
   end

   // cross product operand selection: axis 6 + 3*i + j
   logic [3:0] cidx;
   logic [2:0] ci, cj;
   assign cidx = cmd.axis_idx - 4'd6;
   always_comb begin
      if (cidx >= 4'd6) begin
         ci = 3'd2; cj = 3'(cidx - 4'd6);
      end else if (cidx >= 4'd3) begin
         ci = 3'd1; cj = 3'(cidx - 4'd3);
      end else begin
         ci = 3'd0; cj = 3'(cidx);
      end
   end

   obot_pkg::coord_type ax, ay, az, bx, by, bz;
   assign {az, ay, ax} = norm_ff[ci];
   assign {bz, by, bx} = norm_ff[3'd3 + cj];

   logic signed [XW-1:0] cx_ff, cy_ff, cz_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_cross) begin
         cx_ff <= XW'(ay * bz) - XW'(az * by);
         cy_ff <= XW'(az * bx) - XW'(ax * bz);
         cz_ff <= XW'(ax * by) - XW'(ay * bx);
      end
   end

   function automatic obot_pkg::coord_type fix_axis(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] s;
      s = v >>> obot_pkg::NormalFracBits;
      if (s > XW'((1 <<< (CW - 1)) - 1)) return {1'b0, {(CW-1){1'b1}}};
      if (s < -XW'(1 <<< (CW - 1))) return {1'b1, {(CW-1){1'b0}}};
      return s[CW-1:0];
   endfunction

   obot_pkg::coord_type axx_ff, axy_ff, axz_ff;
   logic zero_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_axis) begin
         if (cmd.axis_idx < 4'd6) begin
            {axz_ff, axy_ff, axx_ff} <= norm_ff[3'(cmd.axis_idx)];
            zero_ff <= (norm_ff[3'(cmd.axis_idx)] == '0);
         end else begin
            axx_ff <= fix_axis(cx_ff);
            axy_ff <= fix_axis(cy_ff);
            axz_ff <= fix_axis(cz_ff);
            zero_ff <= (cx_ff == '0) && (cy_ff == '0) && (cz_ff == '0);
         end
      end
   end

   // stage 1: registered vertex read with its valid, box and first flags
   logic [3*CW-1:0] vrd_ff;
   logic            v1_ff, v2_ff, box2_ff, first2_ff, first1_ff, box1_ff;
   always_ff @(posedge clock) begin
      vrd_ff <= vert_mem[cmd.vert_idx];
      v1_ff <= cmd.scan_step;
      box1_ff <= cmd.vert_idx[3];
      first1_ff <= (cmd.vert_idx[2:0] == 3'd0);
   end

   obot_pkg::coord_type vx, vy, vz;
   assign {vz, vy, vx} = vrd_ff;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   always_ff @(posedge clock) begin
      px_ff <= vx * axx_ff;
      py_ff <= vy * axy_ff;
      pz_ff <= vz * axz_ff;
      v2_ff <= v1_ff;
      box2_ff <= box1_ff;
      first2_ff <= first1_ff;
   end

   logic signed [DW-1:0] dot;
   assign dot = DW'(px_ff) + DW'(py_ff) + DW'(pz_ff);

   logic signed [DW-1:0] mn_ff [2];
   logic signed [DW-1:0] mx_ff [2];
   always_ff @(posedge clock) begin
      if (v2_ff) begin
         if (first2_ff || dot < mn_ff[box2_ff]) mn_ff[box2_ff] <= dot;
         if (first2_ff || dot > mx_ff[box2_ff]) mx_ff[box2_ff] <= dot;
      end
   end

   logic signed [DW-1:0] lo, hi;
   assign lo = (mn_ff[0] > mn_ff[1]) ? mn_ff[0] : mn_ff[1];
   assign hi = (mx_ff[0] < mx_ff[1]) ? mx_ff[0] : mx_ff[1];

   assign status.axis_zero = zero_ff;
   assign status.draining = v1_ff || v2_ff;
   // valid once the pipeline has drained; controller waits for that
   assign status.separated = !zero_ff && !v2_ff && !v1_ff && (lo > hi);
endmodule
`default_nettype wire

// File: hw/rtl/oriented_box_overlap_test.sv
// Top level: stream ports, controller and datapath for the oriented box overlap test.
`default_nettype none
// Load transfers store one vertex or face normal each.
// A transfer with the last flag runs the separating axis test over 15 axes;
// each nonzero axis runs 16 vertex reads through a three stage projection pipe
// plus setup and drain, with a cross product step first for a cross axis; a
// zero axis skips the reads. The single result bit appears when the test ends.
// A separating axis ends the test early. Input is held off while testing.
module oriented_box_overlap_test (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [0] item_kind, [1] box_select, [4:2] slot
   input  wire  [4:0]  req_tuser,
   // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
   input  wire  [47:0] req_tdata,
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] boxes_overlap
   output logic [7:0]  rsp_tdata
);
   obot_pkg::cmd_type    cmd;
   obot_pkg::status_type status;
   logic busy, res_valid, res_bit, take;

   assign req_tready = !busy;
   assign take = req_tvalid && req_tready;

   obot_datapath u_dp (
      .clock(clock),
      .store_en(take),
      .store_kind(req_tuser[0]),
      .store_box(req_tuser[1]),
      .store_slot(req_tuser[4:2]),
      .store_x(req_tdata[15:0]),
      .store_y(req_tdata[31:16]),
      .store_z(req_tdata[47:32]),
      .cmd(cmd),
      .status(status)
   );

   obot_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(take && req_tlast),
      .rsp_taken(rsp_tready),
      .status(status),
      .cmd(cmd),
      .busy(busy),
      .result_valid(res_valid),
      .result_bit(res_bit)
   );

   assign rsp_tvalid = res_valid;
   assign rsp_tdata = {7'd0, res_bit};
endmodule
`default_nettype wire
